>>> design/assert_macros.svh
// Assertion macros used by the block cipher top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/aes_cbc_pkg.sv
// Types, constants and byte functions for the AES-CBC block.
// No dependencies.
package aes_cbc_pkg;

    localparam int BlockW = 128;
    localparam int WordW  = 32;
    localparam int RkDepth = 60;
    localparam int RkAddrW = 6;

    localparam logic [1:0] KeySize128 = 2'd0;
    localparam logic [1:0] KeySize192 = 2'd1;
    localparam logic [1:0] KeySize256 = 2'd2;

    localparam logic [2:0] RegKeySize = 3'd0;
    localparam logic [2:0] RegKey0    = 3'd1;
    localparam logic [2:0] RegKey1    = 3'd2;
    localparam logic [2:0] RegKey2    = 3'd3;
    localparam logic [2:0] RegKey3    = 3'd4;
    localparam logic [2:0] RegIvHigh  = 3'd5;
    localparam logic [2:0] RegIvLow   = 3'd6;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    localparam logic [7:0] XtPoly = 8'h1b;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] r;
        unique case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] r;
        unique case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? XtPoly : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

    // Round constant for expansion step j (1..10), held in the top byte.
    function automatic logic [7:0] rcon(input logic [3:0] j);
        logic [7:0] r;
        case (j)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Byte i of the state (i = 4*column + row) sits at bits 127-8i.
    function automatic logic [7:0] sbyte(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    // Forward round body without key: sub bytes, shift rows, optional mix.
    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic mix);
        logic [127:0] t;
        logic [7:0] p0, p1, p2, p3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = fwd_sbox(sbyte(s, 4*((c + r) % 4) + r));
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                p0 = sbyte(t, 4*c); p1 = sbyte(t, 4*c + 1);
                p2 = sbyte(t, 4*c + 2); p3 = sbyte(t, 4*c + 3);
                al = p0 ^ p1 ^ p2 ^ p3;
                t[127 - 32*c -: 8]      = p0 ^ al ^ xtime(p0 ^ p1);
                t[127 - 32*c - 8 -: 8]  = p1 ^ al ^ xtime(p1 ^ p2);
                t[127 - 32*c - 16 -: 8] = p2 ^ al ^ xtime(p2 ^ p3);
                t[127 - 32*c - 24 -: 8] = p3 ^ al ^ xtime(p3 ^ p0);
            end
        end
        return t;
    endfunction

    // Inverse shift rows and inverse sub bytes.
    function automatic logic [127:0] inv_round(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*((c + r) % 4) + r) -: 8] = inv_sbox(sbyte(s, 4*c + r));
            end
        end
        return t;
    endfunction

    // Multiply by 9, 11, 13 and 14 via doublings.
    function automatic logic [7:0] gm(input logic [7:0] x, input logic [3:0] y);
        logic [7:0] x2, x4, x8;
        x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
        return (y[0] ? x : 8'h00) ^ (y[1] ? x2 : 8'h00) ^ (y[2] ? x4 : 8'h00)
             ^ (y[3] ? x8 : 8'h00);
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a, b, d2, d;
        for (int c = 0; c < 4; c++) begin
            a = sbyte(s, 4*c); b = sbyte(s, 4*c + 1);
            d2 = sbyte(s, 4*c + 2); d = sbyte(s, 4*c + 3);
            t[127 - 32*c -: 8]      = gm(a,4'he) ^ gm(b,4'hb) ^ gm(d2,4'hd) ^ gm(d,4'h9);
            t[127 - 32*c - 8 -: 8]  = gm(a,4'h9) ^ gm(b,4'he) ^ gm(d2,4'hb) ^ gm(d,4'hd);
            t[127 - 32*c - 16 -: 8] = gm(a,4'hd) ^ gm(b,4'h9) ^ gm(d2,4'he) ^ gm(d,4'hb);
            t[127 - 32*c - 24 -: 8] = gm(a,4'hb) ^ gm(b,4'hd) ^ gm(d2,4'h9) ^ gm(d,4'he);
        end
        return t;
    endfunction

endpackage

>>> design/aes_cbc_block_cipher.sv
// AES-CBC block cipher top level: key expansion, round sequencer, chaining.
// Depends on aes_cbc_pkg, aes_cbc_ram and assert_macros.svh.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------
//  s_axis   | in  | tdata = block_high, block_low; tuser = opcode, restart
//  m_axis   | out | tdata = result_high, result_low
//  cfg      | in  | cfg_we / cfg_index / cfg_data, no read-back
//
//  Each transfer first expands the key schedule into the RAM, one 32-bit word
//  a cycle (44, 52 or 60 words), then runs its rounds on the shared round unit,
//  fetching each round key word by word from the single-read RAM in ST_FETCH.
//  A new input block is taken only in ST_IDLE, after the last one has finished.
//  Reset is synchronous: state, configuration, chaining value and output valid
//  clear; schedule contents stay undefined until written. The next block is
//  taken while a result waits; it holds in ST_DONE until the earlier result
//  has been transferred.
`include "assert_macros.svh"

module aes_cbc_block_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
    input  logic [1:0]   s_axis_tuser,  // opcode [0], restart [1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_high [63:0], result_low [127:64]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_LOAD, ST_FETCH, ST_ROUND, ST_DONE
    } state_t;

    state_t state_reg;
    logic [1:0]   key_size_reg;
    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg, iv_hi_reg, iv_lo_reg;
    logic [127:0] chain_reg, blk_in_reg, st_reg, rk_reg, out_reg;
    logic         dec_reg, valid_out_reg;
    logic [5:0]   widx_reg;      // expansion word index
    logic [31:0]  wprev_reg;     // previous schedule word
    logic [255:0] win_reg;       // sliding window of last nk words
    logic [2:0]   kcnt_reg;      // position within nk
    logic [3:0]   jcnt_reg;      // rcon step
    logic [3:0]   round_reg;     // round index under work
    logic [2:0]   fcnt_reg;      // fetch word counter

    logic [3:0] nk, nr;
    logic [5:0] total;
    always_comb begin
        unique case (key_size_reg)
            aes_cbc_pkg::KeySize128: begin nk = 4'd4; nr = 4'd10; end
            aes_cbc_pkg::KeySize192: begin nk = 4'd6; nr = 4'd12; end
            default:                 begin nk = 4'd8; nr = 4'd14; end
        endcase
        total = {nr, 2'b00} + 6'd4;
    end

    // Key RAM
    logic        ram_we;
    logic [5:0]  ram_wa, ram_ra;
    logic [31:0] ram_wd, ram_rd;
    aes_cbc_ram #(.Width(aes_cbc_pkg::WordW), .Depth(aes_cbc_pkg::RkDepth)) u_rk (
        .aclk(aclk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
        .rd_addr(ram_ra), .rd_data(ram_rd)
    );

    // Expansion step: w[i] = w[i-nk] ^ f(w[i-1]); window holds w[i-nk] on top.
    logic [31:0] t_rot, t_exp, w_old, w_new;
    always_comb begin
        t_rot = {wprev_reg[23:0], wprev_reg[31:24]};
        if (kcnt_reg == 3'd0) begin
            t_exp = aes_cbc_pkg::sub_word(t_rot) ^ {aes_cbc_pkg::rcon(jcnt_reg), 24'h0};
        end else if (nk == 4'd8 && kcnt_reg == 3'd4) begin
            t_exp = aes_cbc_pkg::sub_word(wprev_reg);
        end else begin
            t_exp = wprev_reg;
        end
        w_old = win_reg[255:224];
        w_new = w_old ^ t_exp;
    end

    // Shared round unit
    logic [127:0] rnd_out;
    logic         last_round;
    always_comb begin
        last_round = (round_reg == nr);
        if (!dec_reg) begin
            rnd_out = aes_cbc_pkg::fwd_round(st_reg, !last_round) ^ rk_reg;
        end else if (last_round) begin
            rnd_out = aes_cbc_pkg::inv_round(st_reg) ^ rk_reg;
        end else begin
            rnd_out = aes_cbc_pkg::inv_mix(aes_cbc_pkg::inv_round(st_reg) ^ rk_reg);
        end
    end

    // Round key address: encrypt uses round r, decrypt uses nr - r.
    logic [3:0] key_round;
    assign key_round = dec_reg ? (nr - round_reg) : round_reg;

    always_comb begin
        ram_we = (state_reg == ST_EXPAND);
        ram_wa = widx_reg;
        ram_wd = (widx_reg < {2'b00, nk}) ? win_reg[255:224] : w_new;
        ram_ra = {key_round, 2'b00} + {4'b0000, fcnt_reg[1:0]};
    end

    logic s_fire, m_fire, done_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    // result register free, or emptied by this cycle's transfer
    assign done_fire = (state_reg == ST_DONE) && (!valid_out_reg || m_fire);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = valid_out_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

    logic [127:0] chain_use;
    assign chain_use = s_axis_tuser[1] ? {iv_hi_reg, iv_lo_reg} : chain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_size_reg  <= aes_cbc_pkg::KeySize128;
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            iv_hi_reg <= '0; iv_lo_reg <= '0;
            chain_reg     <= '0;
            valid_out_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    aes_cbc_pkg::RegKeySize: key_size_reg <= cfg_data[1:0];
                    aes_cbc_pkg::RegKey0:    key0_reg <= cfg_data;
                    aes_cbc_pkg::RegKey1:    key1_reg <= cfg_data;
                    aes_cbc_pkg::RegKey2:    key2_reg <= cfg_data;
                    aes_cbc_pkg::RegKey3:    key3_reg <= cfg_data;
                    aes_cbc_pkg::RegIvHigh:  iv_hi_reg <= cfg_data;
                    aes_cbc_pkg::RegIvLow:   iv_lo_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (done_fire) begin
                valid_out_reg <= 1'b1;
            end else if (m_fire) begin
                valid_out_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        dec_reg    <= s_axis_tuser[0];
                        blk_in_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        chain_reg  <= chain_use;
                        win_reg    <= {key0_reg, key1_reg, key2_reg, key3_reg};
                        widx_reg   <= '0;
                        kcnt_reg   <= '0;
                        jcnt_reg   <= 4'd1;
                        state_reg  <= ST_EXPAND;
                    end
                end
                ST_EXPAND: begin
                    wprev_reg <= ram_wd;
                    if (widx_reg < {2'b00, nk}) begin
                        if (widx_reg == {2'b00, nk} - 6'd1) begin
                            // rebuild window with the nk key words at the top
                            win_reg <= {key0_reg, key1_reg, key2_reg, key3_reg};
                        end else begin
                            win_reg <= {win_reg[223:0], 32'h0};
                        end
                    end else begin
                        win_reg <= (nk == 4'd4) ? {win_reg[223:128], w_new, 128'h0}
                                 : (nk == 4'd6) ? {win_reg[223:64], w_new, 64'h0}
                                 : {win_reg[223:0], w_new};
                        if (kcnt_reg == 3'(nk - 4'd1)) begin
                            kcnt_reg <= '0;
                        end else begin
                            kcnt_reg <= kcnt_reg + 3'd1;
                        end
                        if (kcnt_reg == 3'd0) begin
                            jcnt_reg <= jcnt_reg + 4'd1;
                        end
                    end
                    if (widx_reg == total - 6'd1) begin
                        round_reg <= '0;
                        fcnt_reg  <= '0;
                        state_reg <= ST_FETCH;
                    end
                    widx_reg <= widx_reg + 6'd1;
                end
                ST_FETCH: begin
                    // address for word fcnt issued; its data arrives in the next cycle
                    if (fcnt_reg != 3'd0) begin
                        rk_reg <= {rk_reg[95:0], ram_rd};
                    end
                    if (fcnt_reg == 3'd4) begin
                        fcnt_reg  <= '0;
                        state_reg <= (round_reg == 4'd0) ? ST_LOAD : ST_ROUND;
                    end else begin
                        fcnt_reg <= fcnt_reg + 3'd1;
                    end
                end
                ST_LOAD: begin
                    st_reg    <= (dec_reg ? blk_in_reg : (blk_in_reg ^ chain_reg)) ^ rk_reg;
                    round_reg <= 4'd1;
                    state_reg <= ST_FETCH;
                end
                ST_ROUND: begin
                    st_reg <= rnd_out;
                    if (last_round) begin
                        state_reg <= ST_DONE;
                    end else begin
                        round_reg <= round_reg + 4'd1;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_DONE: begin
                    if (done_fire) begin
                        if (dec_reg) begin
                            out_reg   <= st_reg ^ chain_reg;
                            chain_reg <= blk_in_reg;
                        end else begin
                            out_reg   <= st_reg;
                            chain_reg <= st_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_axis_tready, "ready while busy")
    `ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == ST_DONE, m_axis_tvalid, "no result after done")
    `ASSERT_IMPL(a_round_range, aclk, aresetn, state_reg == ST_ROUND, round_reg != 4'd0 && round_reg <= nr, "round out of range")
endmodule

>>> design/aes_cbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module aes_cbc_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
